// ----- hdl/sscap_pkg.sv -----
`default_nettype none

package sscap_pkg;

	// Radius fields and the field radius register, 8 fraction bits.
	localparam int RAD_W = 23;
	localparam logic [RAD_W-1:0] RAD_RESET = 23'd25600;

	// Summed radius and its square.
	localparam int SUM_RAD_W = RAD_W + 1;
	localparam int SUM_RAD_SQ_W = 2 * SUM_RAD_W;

	// Reason codes on the result channel.
	localparam int REASON_W = 3;
	localparam logic [REASON_W-1:0] REASON_NO_MOTION = 3'd0;
	localparam logic [REASON_W-1:0] REASON_TOO_FAR   = 3'd1;
	localparam logic [REASON_W-1:0] REASON_AWAY      = 3'd2;
	localparam logic [REASON_W-1:0] REASON_MISS      = 3'd3;
	localparam logic [REASON_W-1:0] REASON_OVERLAP   = 3'd4;
	localparam logic [REASON_W-1:0] REASON_TOUCH     = 3'd5;
	localparam logic [REASON_W-1:0] REASON_SHORT     = 3'd6;

endpackage

`default_nettype wire

// ----- hdl/sscap_isqrt.sv -----
`default_nettype none

// Pipelined floored integer square root, two result bits per stage.
module sscap_isqrt #(
	parameter int ROOT_W = 24,
	parameter int SIDE_W = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  en,
	input  wire logic                  in_vld,
	input  wire logic [2*ROOT_W-1:0]   radicand,
	input  wire logic [SIDE_W-1:0]     in_side,
	output logic                       out_vld,
	output logic      [ROOT_W-1:0]     root,
	output logic      [SIDE_W-1:0]     out_side
);

	localparam int STAGES = (ROOT_W + 1) / 2;

	logic [2*ROOT_W-1:0] rad_s  [STAGES];
	logic [ROOT_W+1:0]   rem_s  [STAGES];
	logic [ROOT_W-1:0]   root_s [STAGES];
	logic [SIDE_W-1:0]   side_s [STAGES];
	logic                vld_s  [STAGES];

	for (genvar g = 0; g < STAGES; g++) begin : g_stage
		logic [2*ROOT_W-1:0] rad_in;
		logic [ROOT_W+1:0]   rem_in;
		logic [ROOT_W-1:0]   root_in;
		logic [SIDE_W-1:0]   side_in;
		logic                vld_in;
		logic [2*ROOT_W-1:0] rad_nx;
		logic [ROOT_W+1:0]   rem_nx;
		logic [ROOT_W-1:0]   root_nx;

		if (g == 0) begin : g_first
			assign rad_in  = radicand;
			assign rem_in  = '0;
			assign root_in = '0;
			assign side_in = in_side;
			assign vld_in  = in_vld;
		end else begin : g_next
			assign rad_in  = rad_s[g-1];
			assign rem_in  = rem_s[g-1];
			assign root_in = root_s[g-1];
			assign side_in = side_s[g-1];
			assign vld_in  = vld_s[g-1];
		end

		// Two restoring root steps: bring down two radicand bits and try root*4+1.
		always_comb begin : p_step
			logic [ROOT_W+2:0] tmp;
			logic [ROOT_W+2:0] trial;
			logic [ROOT_W+2:0] diff;
			rad_nx  = rad_in;
			rem_nx  = rem_in;
			root_nx = root_in;
			tmp     = '0;
			trial   = '0;
			diff    = '0;
			for (int j = 0; j < 2; j++) begin
				if (g * 2 + j < ROOT_W) begin
					tmp    = {rem_nx[ROOT_W:0], rad_nx[2*ROOT_W-1 -: 2]};
					trial  = {1'b0, root_nx, 2'b01};
					diff   = tmp - trial;
					rad_nx = {rad_nx[2*ROOT_W-3:0], 2'b00};
					if (tmp >= trial) begin
						rem_nx  = diff[ROOT_W+1:0];
						root_nx = {root_nx[ROOT_W-2:0], 1'b1};
					end else begin
						rem_nx  = tmp[ROOT_W+1:0];
						root_nx = {root_nx[ROOT_W-2:0], 1'b0};
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[g]  <= rad_nx;
				rem_s[g]  <= rem_nx;
				root_s[g] <= root_nx;
				side_s[g] <= side_in;
			end
		end
	end

	assign out_vld  = vld_s[STAGES-1];
	assign root     = root_s[STAGES-1];
	assign out_side = side_s[STAGES-1];

endmodule

`default_nettype wire

// ----- hdl/sscap_div.sv -----
`default_nettype none

// Pipelined restoring divider, two quotient bits per stage. The caller
// guarantees that the quotient fits in Q_W bits.
module sscap_div #(
	parameter int DVD_W  = 48,
	parameter int DIVR_W = 24,
	parameter int Q_W    = 26,
	parameter int SIDE_W = 8
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire logic                in_vld,
	input  wire logic [DVD_W-1:0]    dividend,
	input  wire logic [DIVR_W-1:0]   divisor,
	input  wire logic [SIDE_W-1:0]   in_side,
	output logic                     out_vld,
	output logic      [Q_W-1:0]      quotient,
	output logic      [DIVR_W-1:0]   out_divisor,
	output logic      [SIDE_W-1:0]   out_side
);

	localparam int STAGES = (Q_W + 1) / 2;

	logic [DIVR_W-1:0] rem_s  [STAGES];
	logic [Q_W-1:0]    lo_s   [STAGES];
	logic [DIVR_W-1:0] divr_s [STAGES];
	logic [SIDE_W-1:0] side_s [STAGES];
	logic              vld_s  [STAGES];

	for (genvar g = 0; g < STAGES; g++) begin : g_stage
		logic [DIVR_W-1:0] rem_in;
		logic [Q_W-1:0]    lo_in;
		logic [DIVR_W-1:0] divr_in;
		logic [SIDE_W-1:0] side_in;
		logic              vld_in;
		logic [DIVR_W-1:0] rem_nx;
		logic [Q_W-1:0]    lo_nx;

		if (g == 0) begin : g_first
			// The bits above the quotient width form a partial remainder below the divisor.
			assign rem_in  = DIVR_W'(dividend >> Q_W);
			assign lo_in   = dividend[Q_W-1:0];
			assign divr_in = divisor;
			assign side_in = in_side;
			assign vld_in  = in_vld;
		end else begin : g_next
			assign rem_in  = rem_s[g-1];
			assign lo_in   = lo_s[g-1];
			assign divr_in = divr_s[g-1];
			assign side_in = side_s[g-1];
			assign vld_in  = vld_s[g-1];
		end

		// Quotient bits shift in at the bottom as dividend bits leave the top.
		always_comb begin : p_step
			logic [DIVR_W:0] tmp;
			logic [DIVR_W:0] diff;
			rem_nx = rem_in;
			lo_nx  = lo_in;
			tmp    = '0;
			diff   = '0;
			for (int j = 0; j < 2; j++) begin
				if (g * 2 + j < Q_W) begin
					tmp  = {rem_nx, lo_nx[Q_W-1]};
					diff = tmp - {1'b0, divr_in};
					if (tmp >= {1'b0, divr_in}) begin
						rem_nx = diff[DIVR_W-1:0];
						lo_nx  = {lo_nx[Q_W-2:0], 1'b1};
					end else begin
						rem_nx = tmp[DIVR_W-1:0];
						lo_nx  = {lo_nx[Q_W-2:0], 1'b0};
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g]  <= rem_nx;
				lo_s[g]   <= lo_nx;
				divr_s[g] <= divr_in;
				side_s[g] <= side_in;
			end
		end
	end

	assign out_vld     = vld_s[STAGES-1];
	assign quotient    = lo_s[STAGES-1];
	assign out_divisor = divr_s[STAGES-1];
	assign out_side    = side_s[STAGES-1];

endmodule

`default_nettype wire

// ----- hdl/swept_sphere_capture_test.sv -----
// Path: the front stages, the motion-length root, the divider, the closest-approach stages,
// the half-chord root and the output register.
// Throughput: one transaction per cycle; the whole pipeline holds while a result is stalled.
// Reset: arst_n clears all valid bits at once and loads field_radius with 100.0; the data
// registers are not reset.
`default_nettype none

module swept_sphere_capture_test #(
	parameter int COORD_BITS = 24
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [sscap_pkg::RAD_W-1:0]   cfg_wdata,
	input  wire logic                          item_valid,
	output logic                               item_stall,
	input  wire logic                          op,
	input  wire logic signed [COORD_BITS-1:0]  offset_x,
	input  wire logic signed [COORD_BITS-1:0]  offset_y,
	input  wire logic signed [COORD_BITS-1:0]  offset_z,
	input  wire logic signed [COORD_BITS-1:0]  rel_vel_x,
	input  wire logic signed [COORD_BITS-1:0]  rel_vel_y,
	input  wire logic signed [COORD_BITS-1:0]  rel_vel_z,
	input  wire logic [sscap_pkg::RAD_W-1:0]   body_radius,
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output logic                               in_field,
	output logic [sscap_pkg::REASON_W-1:0]     reason
);

	localparam int CB   = COORD_BITS;
	localparam int PW   = 2 * CB;
	localparam int QW   = CB + 2;
	localparam int RW   = sscap_pkg::SUM_RAD_W;
	localparam int R2W  = sscap_pkg::SUM_RAD_SQ_W;
	localparam int CMPW = ((PW > R2W) ? PW : R2W) + 1;
	localparam int DW   = ((QW > RW) ? QW : RW) + 1;

	typedef struct packed {
		logic           op;
		logic           m2zero;
		logic           too_far;
		logic           dot_neg;
		logic [PW-1:0]  dabs;
		logic [PW-1:0]  c2;
		logic [R2W-1:0] r2;
	} mag_side_t;

	typedef struct packed {
		logic           op;
		logic           m2zero;
		logic           too_far;
		logic           dot_neg;
		logic [PW-1:0]  c2;
		logic [R2W-1:0] r2;
	} div_side_t;

	typedef struct packed {
		logic          op;
		logic          m2zero;
		logic          too_far;
		logic          away;
		logic          miss;
		logic [QW-1:0] d;
		logic [CB-1:0] mag;
	} root_side_t;

	logic [sscap_pkg::RAD_W-1:0] field_radius_q;
	logic                        en;
	logic                        result_valid_q;
	logic                        in_field_q;
	logic [sscap_pkg::REASON_W-1:0] reason_q;

	// The pipeline moves whenever the output register is free or being emptied.
	assign en         = !result_valid_q || !result_stall;
	assign item_stall = !en;

	// Field radius register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_radius_q <= sscap_pkg::RAD_RESET;
		end else if (cfg_we) begin
			field_radius_q <= cfg_wdata;
		end
	end

	// Stage 1: magnitudes and signs of the six coordinates, summed radius.
	logic [CB-1:0] crd [6];
	assign crd[0] = offset_x;
	assign crd[1] = offset_y;
	assign crd[2] = offset_z;
	assign crd[3] = rel_vel_x;
	assign crd[4] = rel_vel_y;
	assign crd[5] = rel_vel_z;

	logic [CB-1:0] abs_s1 [6];
	logic          neg_s1 [6];
	logic [RW-1:0] r_s1;
	logic          op_s1;
	logic          v_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 6; i++) begin
				abs_s1[i] <= crd[i][CB-1] ? (~crd[i]) + CB'(1) : crd[i];
				neg_s1[i] <= crd[i][CB-1];
			end
			r_s1  <= RW'(field_radius_q) + RW'(body_radius);
			op_s1 <= op;
		end
	end

	// Stage 2: squares and cross products, one multiplier each.
	logic [PW-1:0]  sqc_s2 [3];
	logic [PW-1:0]  sqm_s2 [3];
	logic [PW-1:0]  cm_s2  [3];
	logic           cmn_s2 [3];
	logic [R2W-1:0] r2_s2;
	logic           op_s2;
	logic           v_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sqc_s2[i] <= PW'(abs_s1[i]) * PW'(abs_s1[i]);
				sqm_s2[i] <= PW'(abs_s1[i+3]) * PW'(abs_s1[i+3]);
				cm_s2[i]  <= PW'(abs_s1[i]) * PW'(abs_s1[i+3]);
				cmn_s2[i] <= neg_s1[i] ^ neg_s1[i+3];
			end
			r2_s2 <= R2W'(r_s1) * R2W'(r_s1);
			op_s2 <= op_s1;
		end
	end

	// Stage 3: sums of squares and the dot product split by sign.
	logic [PW-1:0]  c2_s3;
	logic [PW-1:0]  m2_s3;
	logic [PW-1:0]  dpos_s3;
	logic [PW-1:0]  dneg_s3;
	logic [R2W-1:0] r2_s3;
	logic           op_s3;
	logic           v_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			c2_s3   <= sqc_s2[0] + sqc_s2[1] + sqc_s2[2];
			m2_s3   <= sqm_s2[0] + sqm_s2[1] + sqm_s2[2];
			dpos_s3 <= (cmn_s2[0] ? '0 : cm_s2[0]) + (cmn_s2[1] ? '0 : cm_s2[1])
				+ (cmn_s2[2] ? '0 : cm_s2[2]);
			dneg_s3 <= (cmn_s2[0] ? cm_s2[0] : '0) + (cmn_s2[1] ? cm_s2[1] : '0)
				+ (cmn_s2[2] ? cm_s2[2] : '0);
			r2_s3   <= r2_s2;
			op_s3   <= op_s2;
		end
	end

	// Stage 4: dot magnitude and sign, no-motion and too-far flags.
	logic [PW-1:0] m2_s4;
	mag_side_t     mside_s4;
	logic          v_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			m2_s4            <= m2_s3;
			mside_s4.op      <= op_s3;
			mside_s4.m2zero  <= (m2_s3 == '0);
			mside_s4.too_far <= (CMPW'(m2_s3) + CMPW'(r2_s3)) < CMPW'(c2_s3);
			mside_s4.dot_neg <= dpos_s3 < dneg_s3;
			mside_s4.dabs    <= (dpos_s3 >= dneg_s3) ? dpos_s3 - dneg_s3 : dneg_s3 - dpos_s3;
			mside_s4.c2      <= c2_s3;
			mside_s4.r2      <= r2_s3;
		end
	end

	// Valid bits for the front stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= item_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Motion length: floored square root of m2.
	logic          mag_vld;
	logic [CB-1:0] mag_root;
	mag_side_t     mag_side;

	sscap_isqrt #(
		.ROOT_W (CB),
		.SIDE_W ($bits(mag_side_t))
	) u_mag_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (v_s4),
		.radicand (m2_s4),
		.in_side  (mside_s4),
		.out_vld  (mag_vld),
		.root     (mag_root),
		.out_side (mag_side)
	);

	// Projection of the offset on the motion: |dot| / mag.
	div_side_t     dside_in;
	logic          div_vld;
	logic [QW-1:0] div_q;
	logic [CB-1:0] div_mag;
	div_side_t     div_side;

	assign dside_in.op      = mag_side.op;
	assign dside_in.m2zero  = mag_side.m2zero;
	assign dside_in.too_far = mag_side.too_far;
	assign dside_in.dot_neg = mag_side.dot_neg;
	assign dside_in.c2      = mag_side.c2;
	assign dside_in.r2      = mag_side.r2;

	sscap_div #(
		.DVD_W  (PW),
		.DIVR_W (CB),
		.Q_W    (QW),
		.SIDE_W ($bits(div_side_t))
	) u_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_vld      (mag_vld),
		.dividend    (mag_side.dabs),
		.divisor     (mag_root),
		.in_side     (dside_in),
		.out_vld     (div_vld),
		.quotient    (div_q),
		.out_divisor (div_mag),
		.out_side    (div_side)
	);

	// Stage 5: square of the projection.
	logic [2*QW-1:0] dd_s5;
	logic [QW-1:0]   d_s5;
	logic [CB-1:0]   mag_s5;
	div_side_t       side_s5;
	logic            v_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			dd_s5   <= (2*QW)'(div_q) * (2*QW)'(div_q);
			d_s5    <= div_q;
			mag_s5  <= div_mag;
			side_s5 <= div_side;
		end
	end

	// Stage 6: closest-approach square, clamped at zero; moving-away flag.
	logic [PW-1:0]  f_s6;
	logic [R2W-1:0] r2_s6;
	root_side_t     rside_s6;
	logic           v_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			f_s6             <= ((2*QW)'(side_s5.c2) <= dd_s5) ? '0 : PW'((2*QW)'(side_s5.c2) - dd_s5);
			r2_s6            <= side_s5.r2;
			rside_s6.op      <= side_s5.op;
			rside_s6.m2zero  <= side_s5.m2zero;
			rside_s6.too_far <= side_s5.too_far;
			rside_s6.away    <= (d_s5 == '0) || side_s5.dot_neg;
			rside_s6.miss    <= 1'b0;
			rside_s6.d       <= d_s5;
			rside_s6.mag     <= mag_s5;
		end
	end

	// Stage 7: miss flag and the remaining square r2 - F.
	logic [R2W-1:0] t_s7;
	root_side_t     rside_s7;
	logic           v_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			t_s7     <= R2W'(CMPW'(r2_s6) - CMPW'(f_s6));
			rside_s7 <= '{rside_s6.op, rside_s6.m2zero, rside_s6.too_far, rside_s6.away,
				CMPW'(f_s6) > CMPW'(r2_s6), rside_s6.d, rside_s6.mag};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s5 <= div_vld;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// Half chord through the summed-radius sphere: floored square root of T.
	logic          s_vld;
	logic [RW-1:0] s_root;
	root_side_t    s_side;

	sscap_isqrt #(
		.ROOT_W (RW),
		.SIDE_W ($bits(root_side_t))
	) u_chord_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (v_s7),
		.radicand (t_s7),
		.in_side  (rside_s7),
		.out_vld  (s_vld),
		.root     (s_root),
		.out_side (s_side)
	);

	// Verdict: the first rule that matches decides.
	logic [DW-1:0] excess;
	logic          overlap;
	logic          too_short;
	logic          in_field_nx;
	logic [sscap_pkg::REASON_W-1:0] reason_nx;

	assign excess    = DW'(s_side.d) - DW'(s_root);
	assign overlap   = DW'(s_side.d) < DW'(s_root);
	assign too_short = DW'(s_side.mag) < excess;

	always_comb begin
		in_field_nx = 1'b0;
		reason_nx   = sscap_pkg::REASON_NO_MOTION;
		priority if (s_side.m2zero) begin
			in_field_nx = s_side.op;
			reason_nx   = sscap_pkg::REASON_NO_MOTION;
		end else if (s_side.op) begin
			if (s_side.miss) begin
				in_field_nx = 1'b0;
				reason_nx   = sscap_pkg::REASON_MISS;
			end else begin
				in_field_nx = 1'b1;
				reason_nx   = sscap_pkg::REASON_TOUCH;
			end
		end else if (s_side.too_far) begin
			reason_nx = sscap_pkg::REASON_TOO_FAR;
		end else if (s_side.away) begin
			reason_nx = sscap_pkg::REASON_AWAY;
		end else if (s_side.miss) begin
			reason_nx = sscap_pkg::REASON_MISS;
		end else if (overlap) begin
			in_field_nx = 1'b1;
			reason_nx   = sscap_pkg::REASON_OVERLAP;
		end else if (too_short) begin
			reason_nx = sscap_pkg::REASON_SHORT;
		end else begin
			in_field_nx = 1'b1;
			reason_nx   = sscap_pkg::REASON_TOUCH;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (en) begin
			result_valid_q <= s_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			in_field_q <= in_field_nx;
			reason_q   <= reason_nx;
		end
	end

	assign result_valid = result_valid_q;
	assign in_field     = in_field_q;
	assign reason       = reason_q;

endmodule

`default_nettype wire

// ----- hdl/sscap_checker.sv -----
`default_nettype none

module sscap_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              result_valid,
	input wire logic                              result_stall,
	input wire logic                              in_field,
	input wire logic [sscap_pkg::REASON_W-1:0]    reason
);

	// A stalled result transaction holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(in_field) && $stable(reason))
		else $error("stalled result changed");

	// Only defined reason codes leave the block.
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> reason <= sscap_pkg::REASON_SHORT)
		else $error("undefined reason code");

	// Rejection reasons never come with the body in the field.
	a_reject: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (reason == sscap_pkg::REASON_TOO_FAR
			|| reason == sscap_pkg::REASON_AWAY || reason == sscap_pkg::REASON_MISS
			|| reason == sscap_pkg::REASON_SHORT) |-> !in_field)
		else $error("rejected body reported in field");

	// Overlap and touch always keep the body.
	a_keep: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (reason == sscap_pkg::REASON_OVERLAP
			|| reason == sscap_pkg::REASON_TOUCH) |-> in_field)
		else $error("touching body reported outside");

endmodule

bind swept_sphere_capture_test sscap_checker u_sscap_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.in_field     (in_field),
	.reason       (reason)
);

`default_nettype wire

// ----- test/swept_sphere_capture_test_tb.sv -----
`default_nettype none

module swept_sphere_capture_test_tb;

	localparam int CB = 24;
	localparam int RW = sscap_pkg::RAD_W;
	localparam int RSW = sscap_pkg::REASON_W;
	localparam int LATENCY = 45;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic OP_CAPTURE = 1'b0;
	localparam logic OP_RETAIN  = 1'b1;
	localparam logic [CB-1:0] CMAX = 24'h7FFFFF;
	localparam logic [CB-1:0] CMIN = 24'h800000;
	localparam logic [RW-1:0] RMAX = 23'h7FFFFF;

	typedef struct packed {
		logic op;
		logic [CB-1:0] cx, cy, cz, mx, my, mz;
		logic [RW-1:0] rad;
	} pair_t;

	typedef struct packed {
		logic in_field;
		logic [RSW-1:0] reason;
	} verdict_t;

	// One directed row: the pair, and an expected verdict where it is obvious.
	typedef struct {
		pair_t p;
		logic known;
		verdict_t v;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [RW-1:0] cfg_wdata = '0;
	logic item_valid = 1'b0;
	logic item_stall;
	pair_t drv = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic in_field;
	logic [RSW-1:0] reason;

	logic [RW-1:0] model_radius = sscap_pkg::RAD_RESET;
	verdict_t verdicts_due[$];
	row_t stim_rows[$];
	int failures = 0;
	int cycles = 0;
	bit calm = 1'b0;

	swept_sphere_capture_test #(.COORD_BITS(CB)) u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.item_valid(item_valid), .item_stall(item_stall), .op(drv.op),
		.offset_x(drv.cx), .offset_y(drv.cy), .offset_z(drv.cz),
		.rel_vel_x(drv.mx), .rel_vel_y(drv.my), .rel_vel_z(drv.mz),
		.body_radius(drv.rad), .result_valid(result_valid),
		.result_stall(result_stall), .in_field(in_field), .reason(reason)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Floored integer square root of a 64-bit value.
	function automatic logic [63:0] floor_root(logic [63:0] v);
		logic [63:0] r, b;
		r = 64'd0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 64'd0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Expected verdict for one body pair under the current field radius.
	function automatic verdict_t judge_pair(pair_t p);
		logic [63:0] ca[3], ma[3], c2, m2, dp, dn, r, r2, mag, dabs, d, dd, f, t, s;
		logic [CB-1:0] cv[3], mv[3];
		logic neg;
		verdict_t v;
		cv = '{p.cx, p.cy, p.cz};
		mv = '{p.mx, p.my, p.mz};
		c2 = 64'd0; m2 = 64'd0; dp = 64'd0; dn = 64'd0;
		for (int i = 0; i < 3; i++) begin
			ca[i] = cv[i][CB-1] ? (64'd1 << CB) - 64'(cv[i]) : 64'(cv[i]);
			ma[i] = mv[i][CB-1] ? (64'd1 << CB) - 64'(mv[i]) : 64'(mv[i]);
			c2 += ca[i] * ca[i];
			m2 += ma[i] * ma[i];
			if (cv[i][CB-1] != mv[i][CB-1]) dn += ca[i] * ma[i];
			else dp += ca[i] * ma[i];
		end
		r = 64'(model_radius) + 64'(p.rad);
		r2 = r * r;
		if (m2 == 64'd0) return '{p.op, sscap_pkg::REASON_NO_MOTION};
		if (p.op == OP_CAPTURE && m2 + r2 < c2) return '{1'b0, sscap_pkg::REASON_TOO_FAR};
		mag = floor_root(m2);
		neg = dn > dp;
		dabs = neg ? dn - dp : dp - dn;
		d = dabs / mag;
		if (d == 64'd0) neg = 1'b0;
		if (p.op == OP_CAPTURE && (d == 64'd0 || neg)) return '{1'b0, sscap_pkg::REASON_AWAY};
		dd = (d > 64'hFFFFFFFF) ? '1 : d * d;
		f = (dd >= c2) ? 64'd0 : c2 - dd;
		if (f > r2) return '{1'b0, sscap_pkg::REASON_MISS};
		if (p.op == OP_RETAIN) return '{1'b1, sscap_pkg::REASON_TOUCH};
		t = r2 - f;
		s = floor_root(t);
		if (d < s) return '{1'b1, sscap_pkg::REASON_OVERLAP};
		if (mag < d - s) return '{1'b0, sscap_pkg::REASON_SHORT};
		v = '{1'b1, sscap_pkg::REASON_TOUCH};
		return v;
	endfunction

	// Coordinates mostly small so that every verdict turns up, sometimes full range.
	function automatic logic [CB-1:0] rand_coord(int span);
		if ($urandom_range(0, 15) == 0) return CB'($urandom);
		return CB'($signed($urandom_range(0, 2 * span)) - span);
	endfunction

	function automatic pair_t rand_pair();
		pair_t p;
		int span;
		span = 1 << $urandom_range(6, 16);
		p.op = 1'($urandom_range(0, 1));
		p.cx = rand_coord(span); p.cy = rand_coord(span); p.cz = rand_coord(span);
		p.mx = rand_coord(span); p.my = rand_coord(span); p.mz = rand_coord(span);
		if ($urandom_range(0, 3) == 0) begin
			// Aim the motion at the other body.
			p.mx = CB'($signed(p.cx) >>> $urandom_range(0, 3));
			p.my = CB'($signed(p.cy) >>> $urandom_range(0, 3));
			p.mz = CB'($signed(p.cz) >>> $urandom_range(0, 3));
		end
		if ($urandom_range(0, 19) == 0) {p.mx, p.my, p.mz} = '0;
		p.rad = ($urandom_range(0, 7) == 0) ? RW'($urandom) : RW'($urandom_range(0, span));
		return p;
	endfunction

	// Append one directed row to the stimulus table.
	task automatic add_row(input pair_t p, input logic known, input verdict_t v);
		stim_rows = {stim_rows, row_t'{p, known, v}};
	endtask

	// Offer one transaction and hold it until the block takes it. Valid stays high
	// afterwards so that transactions can follow back to back.
	task automatic send_pair(pair_t p);
		int gap;
		if (!calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 17);
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		drv <= p;
		item_valid <= 1'b1;
		verdicts_due = {verdicts_due, judge_pair(p)};
		do @(posedge clk); while (item_stall);
	endtask

	// Stop offering and wait until every expected result has come.
	task automatic drain();
		item_valid <= 1'b0;
		do @(posedge clk); while (verdicts_due.size() != 0);
	endtask

	// Drain the block, then write a new field radius.
	task automatic set_radius(logic [RW-1:0] value);
		drain();
		repeat (LATENCY + 4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		model_radius = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Stall the result channel in random bursts.
	always @(posedge clk) begin
		if (!calm && $urandom_range(0, 7) == 0) result_stall <= 1'b1;
		else if (result_stall && !calm && $urandom_range(0, 3) != 0) result_stall <= 1'b1;
		else result_stall <= 1'b0;
	end

	// Compare each received transaction with the oldest expectation.
	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (verdicts_due.size() == 0) begin
				$error("unexpected result in_field=%0d reason=%0d", in_field, reason);
				failures++;
			end else begin
				want = verdicts_due.pop_front();
				if (in_field !== want.in_field) begin
					$error("in_field expected %0d got %0d", want.in_field, in_field);
					failures++;
				end
				if (reason !== want.reason) begin
					$error("reason expected %0d got %0d", want.reason, reason);
					failures++;
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		pair_t p;
		verdict_t got;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pairs at the extremes and for the no-motion, too-far, away, miss and touch verdicts.
		add_row('{OP_CAPTURE, 24'd256, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 23'd0},
			1'b1, '{1'b0, sscap_pkg::REASON_NO_MOTION});
		add_row('{OP_RETAIN, CMAX, CMIN, CMAX, 24'd0, 24'd0, 24'd0, RMAX},
			1'b1, '{1'b1, sscap_pkg::REASON_NO_MOTION});
		add_row('{OP_CAPTURE, CMAX, CMAX, CMAX, 24'd1, 24'd0, 24'd0, 23'd0},
			1'b1, '{1'b0, sscap_pkg::REASON_TOO_FAR});
		add_row('{OP_CAPTURE, 24'd51200, 24'd0, 24'd0, -24'sd51200, 24'd0, 24'd0,
			23'd0}, 1'b1, '{1'b0, sscap_pkg::REASON_AWAY});
		add_row('{OP_CAPTURE, 24'd0, 24'd100000, 24'd0, 24'd200000, 24'd0, 24'd0,
			23'd0}, 1'b0, '{1'b0, sscap_pkg::REASON_AWAY});
		add_row('{OP_CAPTURE, 24'd0, 24'd0, 24'd0, 24'd256, 24'd0, 24'd0, 23'd0},
			1'b0, '{1'b0, sscap_pkg::REASON_NO_MOTION});
		add_row('{OP_CAPTURE, 24'd51200, 24'd0, 24'd0, 24'd51200, 24'd0, 24'd0,
			23'd0}, 1'b0, '{1'b0, sscap_pkg::REASON_NO_MOTION});
		add_row('{OP_CAPTURE, 24'd60000, 24'd0, 24'd0, 24'd40000, 24'd0, 24'd0,
			23'd0}, 1'b0, '{1'b0, sscap_pkg::REASON_NO_MOTION});
		add_row('{OP_CAPTURE, 24'd200000, 24'd60000, 24'd0, 24'd100000, 24'd0,
			24'd0, 23'd0}, 1'b0, '{1'b0, sscap_pkg::REASON_NO_MOTION});
		add_row('{OP_RETAIN, 24'd200000, 24'd60000, 24'd0, 24'd100000, 24'd0,
			24'd0, 23'd0}, 1'b0, '{1'b0, sscap_pkg::REASON_NO_MOTION});
		add_row('{OP_RETAIN, 24'd1000, 24'd0, 24'd0, 24'd5, 24'd0, 24'd0, 23'd0},
			1'b0, '{1'b0, sscap_pkg::REASON_NO_MOTION});
		add_row('{OP_CAPTURE, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, RMAX},
			1'b0, '{1'b0, sscap_pkg::REASON_NO_MOTION});
		add_row('{OP_RETAIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, RMAX},
			1'b0, '{1'b0, sscap_pkg::REASON_NO_MOTION});
		add_row('{OP_CAPTURE, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 23'd0},
			1'b0, '{1'b0, sscap_pkg::REASON_NO_MOTION});
		add_row('{OP_RETAIN, 24'hFFFFFF, 24'd1, 24'hFFFFFF, 24'd1, 24'hFFFFFF,
			24'd1, 23'd1}, 1'b0, '{1'b0, sscap_pkg::REASON_NO_MOTION});
		foreach (stim_rows[i]) begin
			p = stim_rows[i].p;
			got = judge_pair(p);
			if (stim_rows[i].known && got != stim_rows[i].v) begin
				$error("row %0d: predictor gives reason %0d, table %0d", i, got.reason,
					stim_rows[i].v.reason);
				failures++;
			end
			send_pair(p);
		end

		// Random pairs under several field radii, extremes included.
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: set_radius('0);
				1: set_radius(RMAX);
				2: set_radius(RW'($urandom_range(1, 4096)));
				3: set_radius(RW'($urandom));
				default: set_radius(sscap_pkg::RAD_RESET);
			endcase
			for (int n = 0; n < 260; n++) begin
				if (phase == 4 && n == 130) drain();
				if (phase == 4 && n == 180) calm = 1'b1;
				send_pair(rand_pair());
			end
		end

		drain();
		repeat (LATENCY + 10) @(posedge clk);
		if (failures == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire
